// ===== rtl/core/urlus_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the URL unescape and split core.
package urlus_pkg;

  // Component state codes
  localparam logic [2:0] CS_SCHEME = 3'd0;
  localparam logic [2:0] CS_HOST   = 3'd1;
  localparam logic [2:0] CS_PORT   = 3'd2;
  localparam logic [2:0] CS_PATH   = 3'd3;
  localparam logic [2:0] CS_QUERY  = 3'd4;
  localparam logic [2:0] CS_ENDED  = 3'd5;
  localparam logic [2:0] CS_CLOSED = 3'd6;

  // Part tags on the result channel
  localparam logic [1:0] PART_SCHEME = 2'd0;
  localparam logic [1:0] PART_HOST   = 2'd1;
  localparam logic [1:0] PART_PORT   = 2'd2;
  localparam logic [1:0] PART_PATH   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_SEP    = 2'd1;
  localparam logic [1:0] ERR_BAD_HEX   = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Escape phases
  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HI   = 2'd2;
  localparam logic [1:0] ESC_BAD  = 2'd3;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       has_byte;
    logic [1:0] part;
    logic       url_done;
    logic [1:0] error_code;
    logic       run_last;
  } res_t;

  // Hex digit decode: {invalid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        hex_val = {1'b0, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
        hex_val = {1'b0, d[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
        hex_val = {1'b0, d[3:0]};
      end else begin
        hex_val = 5'b1_0000;
      end
    end
  endfunction

  function automatic res_t mk_char(input logic [7:0] c, input logic [1:0] part);
    res_t r;
    begin
      r.byte_val   = c;
      r.has_byte   = 1'b1;
      r.part       = part;
      r.url_done   = 1'b0;
      r.error_code = ERR_NONE;
      r.run_last   = 1'b0;
      mk_char = r;
    end
  endfunction

  function automatic res_t mk_status(input logic [1:0] err);
    res_t r;
    begin
      r.byte_val   = CH_NUL;
      r.has_byte   = 1'b0;
      r.part       = PART_SCHEME;
      r.url_done   = 1'b1;
      r.error_code = err;
      r.run_last   = 1'b0;
      mk_status = r;
    end
  endfunction

endpackage

// ===== rtl/core/url_unescape_and_split_core.sv =====
`timescale 1ns / 1ps
// Top level: URL percent decoder and scheme/host/port/path splitter.
//
// Usage
//   Input channel (in_valid/in_ready): one raw URL character per beat, with
//   in_last marking the final character. Output channel (out_valid/out_ready):
//   one result per beat, either a decoded character tagged with its part
//   (scheme, host, port, path) or, after the last character, a status beat
//   with url_done set and the error code. out_run_last marks the final result
//   caused by one input beat.
// Order: a character accepted into the input register is decoded once the
//   result queue is free, and its first result is presented from then on.
// Throughput: one input beat per cycle while each character gives at most
//   one result and out_ready is high. A character that gives several results
//   (held "://" bytes flushed, status beat) holds the result queue until they
//   drain; the input register still takes one more beat meanwhile.
// Reset: synchronous, active low; the splitter returns to the scheme state
//   and both the input register and the result queue are emptied.
// Stall: with out_ready low the result queue holds its beats; the input
//   register fills, then in_ready drops until the queue drains.
module url_unescape_and_split_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic [1:0] out_part,
  output logic       out_url_done,
  output logic [1:0] out_error_code,
  output logic       out_run_last
);
  import urlus_pkg::*;

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Splitter state
  logic [1:0] esc_r,  esc_nxt;
  logic [3:0] hn_r,   hn_nxt;
  logic [2:0] cs_r,   cs_nxt;
  logic [1:0] ps_r,   ps_nxt;
  logic [1:0] el_r,   el_nxt;

  // Result queue: filled at once, drained one beat per cycle while out_ready is high
  res_t       res_r [MAX_RES];
  res_t       res_nxt [MAX_RES];
  logic [2:0] cnt_r;
  logic [2:0] n_nxt;
  logic [1:0] rd_r;

  logic       drain;
  logic       proc;
  logic       in_acc;

  // Decode scratch
  logic       dlv;
  logic [7:0] dlv_c;
  logic [4:0] hv;

  assign out_valid = (cnt_r != 3'd0);
  assign drain     = out_valid && out_ready;
  // Queue can take the next character when empty or emptying this cycle
  assign proc      = in_vld_r && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready));
  assign in_ready  = !in_vld_r || proc;
  assign in_acc    = in_valid && in_ready;

  assign out_byte       = res_r[rd_r].byte_val;
  assign out_has_byte   = res_r[rd_r].has_byte;
  assign out_part       = res_r[rd_r].part;
  assign out_url_done   = res_r[rd_r].url_done;
  assign out_error_code = res_r[rd_r].error_code;
  assign out_run_last   = res_r[rd_r].run_last;

  always_comb begin
    esc_nxt = esc_r;
    hn_nxt  = hn_r;
    cs_nxt  = cs_r;
    ps_nxt  = ps_r;
    el_nxt  = el_r;
    n_nxt   = 3'd0;
    dlv     = 1'b0;
    dlv_c   = in_byte_r;
    hv      = hex_val(in_byte_r);
    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i] = mk_status(ERR_NONE);
    end

    // Percent decoding
    if (cs_r < CS_CLOSED) begin
      if (esc_r == ESC_IDLE) begin
        if (in_byte_r == CH_PCT) begin
          esc_nxt = ESC_PCT;
        end else if (in_byte_r == CH_NUL) begin
          // raw zero ends the URL text
          if (cs_r == CS_SCHEME) begin
            if (ps_nxt >= 2'd1) begin
              res_nxt[n_nxt[1:0]] = mk_char(CH_COLON, PART_SCHEME);
              n_nxt = n_nxt + 3'd1;
            end
            if (ps_nxt >= 2'd2) begin
              res_nxt[n_nxt[1:0]] = mk_char(CH_SLASH, PART_SCHEME);
              n_nxt = n_nxt + 3'd1;
            end
            ps_nxt = 2'd0;
            if (el_nxt == ERR_NONE) el_nxt = ERR_NO_SEP;
          end
          cs_nxt = CS_CLOSED;
        end else begin
          dlv = 1'b1;
        end
      end else if (in_byte_r == CH_NUL) begin
        if (el_nxt < ERR_BAD_HEX) el_nxt = ERR_TRUNCATED;
        cs_nxt  = CS_CLOSED;
        esc_nxt = ESC_IDLE;
      end else if (esc_r == ESC_PCT) begin
        if (!hv[4]) begin
          hn_nxt  = hv[3:0];
          esc_nxt = ESC_HI;
        end else begin
          esc_nxt = ESC_BAD;
        end
      end else if (esc_r == ESC_HI && !hv[4]) begin
        esc_nxt = ESC_IDLE;
        dlv     = 1'b1;
        dlv_c   = {hn_r, hv[3:0]};
      end else begin
        if (el_nxt < ERR_BAD_HEX) el_nxt = ERR_BAD_HEX;
        cs_nxt  = CS_CLOSED;
        esc_nxt = ESC_IDLE;
      end
    end

    // Component split of one decoded character
    if (dlv) begin
      if (dlv_c == CH_NUL) begin
        if (cs_r == CS_SCHEME) begin
          if (ps_nxt >= 2'd1) begin
            res_nxt[n_nxt[1:0]] = mk_char(CH_COLON, PART_SCHEME);
            n_nxt = n_nxt + 3'd1;
          end
          if (ps_nxt >= 2'd2) begin
            res_nxt[n_nxt[1:0]] = mk_char(CH_SLASH, PART_SCHEME);
            n_nxt = n_nxt + 3'd1;
          end
          ps_nxt = 2'd0;
          if (el_nxt == ERR_NONE) el_nxt = ERR_NO_SEP;
        end
        if (cs_r < CS_ENDED) cs_nxt = CS_ENDED;
      end else begin
        case (cs_r)
          CS_SCHEME: begin
            if (ps_r == 2'd0) begin
              if (dlv_c == CH_COLON) begin
                ps_nxt = 2'd1;
              end else begin
                res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_SCHEME);
                n_nxt = n_nxt + 3'd1;
              end
            end else if (ps_r == 2'd1 && dlv_c == CH_SLASH) begin
              ps_nxt = 2'd2;
            end else if (ps_r == 2'd2 && dlv_c == CH_SLASH) begin
              ps_nxt = 2'd0;
              cs_nxt = CS_HOST;
            end else begin
              // failed "://" match: held bytes go out first
              if (ps_r >= 2'd1) begin
                res_nxt[n_nxt[1:0]] = mk_char(CH_COLON, PART_SCHEME);
                n_nxt = n_nxt + 3'd1;
              end
              if (ps_r >= 2'd2) begin
                res_nxt[n_nxt[1:0]] = mk_char(CH_SLASH, PART_SCHEME);
                n_nxt = n_nxt + 3'd1;
              end
              if (dlv_c == CH_COLON) begin
                ps_nxt = 2'd1;
              end else begin
                ps_nxt = 2'd0;
                res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_SCHEME);
                n_nxt = n_nxt + 3'd1;
              end
            end
          end
          CS_HOST: begin
            if (dlv_c == CH_COLON) begin
              cs_nxt = CS_PORT;
            end else if (dlv_c == CH_SLASH) begin
              cs_nxt = CS_PATH;
              res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_PATH);
              n_nxt = n_nxt + 3'd1;
            end else begin
              res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_HOST);
              n_nxt = n_nxt + 3'd1;
            end
          end
          CS_PORT: begin
            if (dlv_c == CH_SLASH) begin
              cs_nxt = CS_PATH;
              res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_PATH);
            end else begin
              res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_PORT);
            end
            n_nxt = n_nxt + 3'd1;
          end
          CS_PATH: begin
            if (dlv_c == CH_QUERY) begin
              cs_nxt = CS_QUERY;
            end else begin
              res_nxt[n_nxt[1:0]] = mk_char(dlv_c, PART_PATH);
              n_nxt = n_nxt + 3'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // End of URL: status beat, then back to reset state
    if (in_last_r) begin
      if (esc_nxt != ESC_IDLE && el_nxt < ERR_BAD_HEX) el_nxt = ERR_TRUNCATED;
      if (cs_nxt == CS_SCHEME) begin
        if (ps_nxt >= 2'd1) begin
          res_nxt[n_nxt[1:0]] = mk_char(CH_COLON, PART_SCHEME);
          n_nxt = n_nxt + 3'd1;
        end
        if (ps_nxt >= 2'd2) begin
          res_nxt[n_nxt[1:0]] = mk_char(CH_SLASH, PART_SCHEME);
          n_nxt = n_nxt + 3'd1;
        end
        if (el_nxt == ERR_NONE) el_nxt = ERR_NO_SEP;
      end
      res_nxt[n_nxt[1:0]] = mk_status(el_nxt);
      n_nxt   = n_nxt + 3'd1;
      esc_nxt = ESC_IDLE;
      hn_nxt  = 4'd0;
      cs_nxt  = CS_SCHEME;
      ps_nxt  = 2'd0;
      el_nxt  = ERR_NONE;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i].run_last = (n_nxt == 3'(i + 1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      esc_r    <= ESC_IDLE;
      hn_r     <= 4'd0;
      cs_r     <= CS_SCHEME;
      ps_r     <= 2'd0;
      el_r     <= ERR_NONE;
      cnt_r    <= 3'd0;
      rd_r     <= 2'd0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (proc) begin
        in_vld_r <= 1'b0;
      end
      if (proc) begin
        esc_r <= esc_nxt;
        hn_r  <= hn_nxt;
        cs_r  <= cs_nxt;
        ps_r  <= ps_nxt;
        el_r  <= el_nxt;
        cnt_r <= n_nxt;
        rd_r  <= 2'd0;
      end else if (drain) begin
        cnt_r <= cnt_r - 3'd1;
        rd_r  <= rd_r + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
    if (proc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MAX_RES))
    else $error("result queue count out of range");

  a_run_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_last == (cnt_r == 3'd1)))
    else $error("run_last not on the final queued beat");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_url_done) |-> out_run_last)
    else $error("status beat not last of its run");

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_last_r) |=> (cs_r == CS_SCHEME && el_r == ERR_NONE && ps_r == 2'd0))
    else $error("splitter state not cleared after end of URL");

  a_proc_queue_free: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (cnt_r == 3'd0 || (cnt_r == 3'd1 && drain)))
    else $error("queue overwritten while holding beats");

endmodule
